FILE: design/hps_pkg.sv
package hps_pkg;

    localparam int unsigned DATA_W    = 8;
    localparam int unsigned ADDR_W    = 8;
    localparam int unsigned MEM_DEPTH = 1 << ADDR_W;
    localparam int unsigned NIB_W     = 4;

    localparam logic [DATA_W-1:0] HALT_OPERAND = 8'hFE;

    typedef logic [DATA_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [NIB_W-1:0]  t_opcode;

    typedef enum logic [1:0] {
        ACT_EXEC  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_RESP
    } t_state;

    localparam t_opcode OP_LDA_DIR = 4'h0;
    localparam t_opcode OP_LDB_DIR = 4'h1;
    localparam t_opcode OP_STA_DIR = 4'h2;
    localparam t_opcode OP_LDA_IMM = 4'h3;
    localparam t_opcode OP_LDB_IMM = 4'h4;
    localparam t_opcode OP_LDA_PC  = 4'h5;
    localparam t_opcode OP_LDA_IDX = 4'h6;
    localparam t_opcode OP_LDB_IDX = 4'h7;
    localparam t_opcode OP_STA_IDX = 4'h8;
    localparam t_opcode OP_BR      = 4'h9;
    localparam t_opcode OP_BRZ     = 4'hA;
    localparam t_opcode OP_BRN     = 4'hB;
    localparam t_opcode OP_BR_B    = 4'hC;
    localparam t_opcode OP_ADD     = 4'hD;
    localparam t_opcode OP_SUB     = 4'hE;
    localparam t_opcode OP_PFIX    = 4'hF;

endpackage

FILE: design/hex_processor_step.sv
// Eight-bit accumulator processor with a 256-byte unified memory held in one single-port
// synchronous RAM (one read or one write per cycle, read data in the next cycle). Each input beat
// is an execute, a memory write or a memory read, and each gives exactly one result beat with
// pc, A, B, the halt flag and the read byte. Memory writes, memory reads and instructions that
// only touch registers or the pc run without a gap while the output is not stalled; loads and
// stores hold up the next beat, because the instruction fetch and the data access share the single
// RAM port. The fetch address of the next instruction is forwarded from the one finishing, so
// instructions after any but a store follow without a gap. A result waits in an output register
// while the output is stalled; a new beat is taken meanwhile, and its work stops at its result until
// the register frees. After reset the memory reads as all zero, tracked by one valid bit per byte.
module hex_processor_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  hps_pkg::t_addr       i_mem_address,
    input  hps_pkg::t_byte       i_mem_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output hps_pkg::t_byte       o_pc_now,
    output hps_pkg::t_byte       o_a_now,
    output hps_pkg::t_byte       o_b_now,
    output logic                 o_halted,
    output hps_pkg::t_byte       o_read_data
);
    import hps_pkg::*;

    t_state  r_state, n_state;
    t_byte   r_pc, n_pc;
    t_byte   r_a, n_a;
    t_byte   r_b, n_b;
    t_byte   r_opr, n_opr;
    logic    r_halted, n_halted;
    logic    r_ld_b, n_ld_b;
    logic [1:0] r_act;

    t_byte   r_mem [MEM_DEPTH];
    logic    r_mem_vld [MEM_DEPTH];
    t_byte   r_rdq;
    logic    r_rvld;
    t_byte   rdata;

    logic    mem_en, mem_we;
    t_addr   mem_addr;
    t_byte   mem_wdata;

    logic    r_out_valid;
    t_byte   r_out_pc, r_out_a, r_out_b, r_out_rd;
    logic    r_out_halted;

    logic    out_free, finish, take_ok, acc, is_load, is_store;
    t_opcode opc;
    t_byte   opr, pc1;
    t_byte   resp_rd;

    assign rdata    = r_rvld ? r_rdq : '0;
    assign out_free = !r_out_valid || !i_stall;
    assign opc      = rdata[DATA_W-1 -: NIB_W];
    assign opr      = r_opr | {{(DATA_W-NIB_W){1'b0}}, rdata[NIB_W-1:0]};
    assign pc1      = r_pc + t_byte'(1);
    assign resp_rd  = (r_state == ST_RESP && r_act == ACT_READ) ? rdata : '0;

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_a       = r_a;
        n_b       = r_b;
        n_opr     = r_opr;
        n_halted  = r_halted;
        n_ld_b    = r_ld_b;
        finish    = 1'b0;
        is_load   = 1'b0;
        is_store  = 1'b0;
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = r_a;

        unique case (r_state)
            ST_IDLE: begin
            end
            ST_RESP: begin
                finish = out_free;
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD: begin
                finish = out_free;
                if (finish) begin
                    n_state = ST_IDLE;
                    if (r_ld_b) begin
                        n_b = rdata;
                    end else begin
                        n_a = rdata;
                    end
                end
            end
            ST_DECODE: begin
                n_pc    = pc1;
                n_opr   = '0;
                n_state = ST_IDLE;
                unique case (opc) inside
                    OP_LDA_DIR, OP_LDB_DIR: begin
                        is_load  = 1'b1;
                        mem_addr = opr;
                    end
                    OP_LDA_IDX: begin
                        is_load  = 1'b1;
                        mem_addr = r_a + opr;
                    end
                    OP_LDB_IDX: begin
                        is_load  = 1'b1;
                        mem_addr = r_b + opr;
                    end
                    OP_STA_DIR: begin
                        is_store = 1'b1;
                        mem_addr = opr;
                    end
                    OP_STA_IDX: begin
                        is_store = 1'b1;
                        mem_addr = r_b + opr;
                    end
                    OP_LDA_IMM: n_a = opr;
                    OP_LDB_IMM: n_b = opr;
                    OP_LDA_PC:  n_a = pc1 + opr;
                    OP_BR: begin
                        n_pc = pc1 + opr;
                        if (opr == HALT_OPERAND) begin
                            n_halted = 1'b1;
                        end
                    end
                    OP_BRZ: begin
                        if (r_a == '0) begin
                            n_pc = pc1 + opr;
                        end
                    end
                    OP_BRN: begin
                        if (r_a[DATA_W-1]) begin
                            n_pc = pc1 + opr;
                        end
                    end
                    OP_BR_B: n_pc = r_b;
                    OP_ADD:  n_a = r_a + r_b;
                    OP_SUB:  n_a = r_a - r_b;
                    OP_PFIX: n_opr = {opr[NIB_W-1:0], {NIB_W{1'b0}}};
                    default: begin
                    end
                endcase

                n_ld_b = (opc == OP_LDB_DIR) || (opc == OP_LDB_IDX);
                if (is_load) begin
                    // A load moves on to its data read without waiting on the output.
                    mem_en  = 1'b1;
                    n_state = ST_LOAD;
                end else if (out_free) begin
                    finish = 1'b1;
                    mem_en = is_store;
                    mem_we = is_store;
                end else begin
                    n_state  = ST_DECODE;
                    n_pc     = r_pc;
                    n_a      = r_a;
                    n_b      = r_b;
                    n_opr    = r_opr;
                    n_halted = r_halted;
                end
            end
            default: begin
            end
        endcase

        // A store owns the memory port in its last cycle, so no fetch can start then.
        take_ok = (r_state == ST_IDLE) || (finish && !is_store);
        acc     = i_valid && take_ok;

        if (acc) begin
            n_state = ST_RESP;
            case (i_action)
                ACT_EXEC: begin
                    if (!n_halted) begin
                        mem_en   = 1'b1;
                        mem_addr = n_pc;
                        n_state  = ST_DECODE;
                    end
                end
                ACT_WRITE: begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = i_mem_address;
                    mem_wdata = i_mem_data;
                end
                ACT_READ: begin
                    mem_en   = 1'b1;
                    mem_addr = i_mem_address;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stall = !take_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_opr    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_a      <= n_a;
            r_b      <= n_b;
            r_opr    <= n_opr;
            r_halted <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld_b <= n_ld_b;
        if (acc) begin
            r_act <= i_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_DEPTH; i++) begin
                r_mem_vld[i] <= 1'b0;
            end
        end else if (mem_en && mem_we) begin
            r_mem_vld[mem_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_en) begin
            if (mem_we) begin
                r_mem[mem_addr] <= mem_wdata;
            end else begin
                r_rdq  <= r_mem[mem_addr];
                r_rvld <= r_mem_vld[mem_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_pc     <= n_pc;
            r_out_a      <= n_a;
            r_out_b      <= n_b;
            r_out_halted <= n_halted;
            r_out_rd     <= resp_rd;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pc_now    = r_out_pc;
    assign o_a_now     = r_out_a;
    assign o_b_now     = r_out_b;
    assign o_halted    = r_out_halted;
    assign o_read_data = r_out_rd;

endmodule

FILE: design/hps_checker.sv
module hps_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  logic [1:0]           i_action,
    input  hps_pkg::t_addr       i_mem_address,
    input  hps_pkg::t_byte       i_mem_data,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  hps_pkg::t_byte       o_pc_now,
    input  hps_pkg::t_byte       o_a_now,
    input  hps_pkg::t_byte       o_b_now,
    input  logic                 o_halted,
    input  hps_pkg::t_byte       o_read_data
);
    import hps_pkg::*;

    logic r_seen_halt;
    logic out_beat;

    assign out_beat = o_valid && !i_stall;

    // Remembers that a delivered beat already reported the machine as halted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (out_beat && o_halted) begin
            r_seen_halt <= 1'b1;
        end
    end

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_pc_now) && $stable(o_a_now) && $stable(o_b_now)
            && $stable(o_halted) && $stable(o_read_data))
        else $error("result payload changed while stalled");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && r_seen_halt |-> o_halted)
        else $error("halt flag cleared without reset");

endmodule

bind hex_processor_step hps_checker u_hps_checker (.*);
